FILE: hw/rtl/evsw_pkg.sv
package evsw_pkg;

	localparam int IN_W      = 64;
	localparam int RATE_W    = 18;
	localparam int RATE_BITS = 16;
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd46811;
	localparam int LN2_W     = 28;
	localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065280;

	typedef struct packed {
		logic load;
		logic norm_step;
		logic sqr_init;
		logic sqr_step;
		logic log_step;
		logic sum_step;
		logic mul_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic norm_done;
		logic full;
	} stat_t;

endpackage

FILE: hw/rtl/erlang_variate_sliding_window_core.sv
// one word is worked at a time: in_ready is high only in idle; the work per word is set by the
// normalize shifter (8 or 1 bit a cycle) and the FRAC_BITS+4 steps of the shared log2 squarer
// no result until WINDOW words have arrived, then one result per word
// reset: window sum, fill count and write position clear, inverse_rate returns to 1/1.4
module erlang_variate_sliding_window_core #(
	parameter int WINDOW    = 7,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [evsw_pkg::IN_W-1:0]   uniform_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [FRAC_BITS+4:0]        variate,
	output logic                        clamped,
	input  logic                        cfg_we,
	input  logic [evsw_pkg::RATE_W-1:0] inverse_rate
);
	import evsw_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	evsw_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	evsw_dp #(.WINDOW(WINDOW), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.uniform_word(uniform_word),
		.cfg_we(cfg_we), .inverse_rate(inverse_rate),
		.cmd(cmd), .stat(stat),
		.variate(variate), .clamped(clamped)
	);

endmodule

FILE: hw/rtl/evsw_ctrl.sv
module evsw_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  evsw_pkg::stat_t stat,
	output evsw_pkg::cmd_t  cmd
);
	import evsw_pkg::*;

	localparam int LOG_EXTRA = FRAC_BITS + 4;
	localparam int CNT_W = $clog2(LOG_EXTRA);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NORM = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_LOG  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) out_valid_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (stat.norm_done) begin
					cmd.sqr_init = 1'b1;
					cnt_d = '0;
					state_d = ST_SQR;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			ST_SQR: begin
				cmd.sqr_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(LOG_EXTRA - 1)) state_d = ST_LOG;
			end
			ST_LOG: begin
				cmd.log_step = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				state_d = stat.full ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

FILE: hw/rtl/evsw_dp.sv
module evsw_dp #(
	parameter int WINDOW    = 7,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [evsw_pkg::IN_W-1:0]     uniform_word,
	input  logic                          cfg_we,
	input  logic [evsw_pkg::RATE_W-1:0]   inverse_rate,
	input  evsw_pkg::cmd_t                cmd,
	output evsw_pkg::stat_t               stat,
	output logic [FRAC_BITS+4:0]          variate,
	output logic                          clamped
);
	import evsw_pkg::*;

	localparam int LOG_EXTRA = FRAC_BITS + 4;
	localparam int LOG_W  = FRAC_BITS + 6;
	localparam int L2_W   = LOG_EXTRA + 7;
	localparam int PROD_W = L2_W + LN2_W;
	localparam int RND_W  = PROD_W + 1 - 32;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int WP_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = LOG_W + FILL_W;
	localparam int MP_W   = SUM_W + RATE_W;
	localparam int V_W    = MP_W + 1 - RATE_BITS;
	localparam int VAR_W  = FRAC_BITS + 5;
	localparam logic [LOG_W-1:0] LOG_MAX = '1;
	localparam logic [V_W-1:0] LIMIT = V_W'(20) << FRAC_BITS;

	logic [IN_W-1:0] word_q;
	logic [5:0] n_q;
	logic zero_q;
	logic [31:0] m_q;
	logic [LOG_EXTRA-1:0] frac_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0] sum_q;
	logic [FILL_W-1:0] fill_q;
	logic [WP_W-1:0] wp_q;
	logic [LOG_W-1:0] win_q [WINDOW];
	logic [MP_W-1:0] mp_q;
	logic [RATE_W-1:0] rate_q;
	logic [VAR_W-1:0] var_q;
	logic clamp_q;

	logic [63:0] sq;
	logic [32:0] sq_t;
	logic [L2_W-1:0] l2;
	logic [RND_W-1:0] rnd;
	logic [LOG_W-1:0] lv;
	logic [V_W-1:0] v;
	logic full_now;

	assign sq   = 64'(m_q) * 64'(m_q);
	assign sq_t = sq[63:31];
	assign l2   = (L2_W'({1'b0, n_q} + 7'd1) << LOG_EXTRA) - L2_W'(frac_q);
	assign rnd  = RND_W'(({1'b0, prod_q} + ((PROD_W+1)'(1) << 31)) >> 32);
	always_comb begin
		if (zero_q || rnd > RND_W'(LOG_MAX)) lv = LOG_MAX;
		else lv = LOG_W'(rnd);
	end
	assign full_now = (fill_q == FILL_W'(WINDOW));
	assign v = V_W'(({1'b0, mp_q} + ((MP_W+1)'(1) << (RATE_BITS - 1))) >> RATE_BITS);

	assign stat.norm_done = word_q[IN_W-1] | zero_q;
	assign stat.full = full_now;
	assign variate = var_q;
	assign clamped = clamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			sum_q <= '0;
			fill_q <= '0;
			wp_q <= '0;
		end else begin
			if (cfg_we) rate_q <= inverse_rate;
			if (cmd.sum_step) begin
				// drop the oldest log once the window is full
				sum_q <= sum_q - (full_now ? SUM_W'(win_q[wp_q]) : '0) + SUM_W'(lv);
				wp_q <= (wp_q == WP_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
				if (!full_now) fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= uniform_word;
			zero_q <= (uniform_word == '0);
			n_q <= '0;
		end
		if (cmd.norm_step) begin
			if (word_q[IN_W-1 -: 8] == 8'd0) begin
				word_q <= word_q << 8;
				n_q <= n_q + 6'd8;
			end else begin
				word_q <= word_q << 1;
				n_q <= n_q + 6'd1;
			end
		end
		if (cmd.sqr_init) begin
			m_q <= word_q[IN_W-1 -: 32];
			frac_q <= '0;
		end
		if (cmd.sqr_step) begin
			if (sq_t[32]) begin
				m_q <= sq_t[32:1];
				frac_q <= {frac_q[LOG_EXTRA-2:0], 1'b1};
			end else begin
				m_q <= sq_t[31:0];
				frac_q <= {frac_q[LOG_EXTRA-2:0], 1'b0};
			end
		end
		if (cmd.log_step) prod_q <= PROD_W'(l2) * PROD_W'(LN2_Q28);
		if (cmd.sum_step) win_q[wp_q] <= lv;
		if (cmd.mul_step) mp_q <= MP_W'(sum_q) * MP_W'(rate_q);
		if (cmd.out_load) begin
			if (v > LIMIT) begin
				var_q <= VAR_W'(LIMIT);
				clamp_q <= 1'b1;
			end else begin
				var_q <= VAR_W'(v);
				clamp_q <= 1'b0;
			end
		end
	end

endmodule

FILE: dv/erlang_variate_sliding_window_core_tb.sv
`timescale 1ns / 100ps

module erlang_variate_sliding_window_core_tb;

	localparam int WIN = 7;
	localparam int FB = 16;
	localparam logic [63:0] LIMIT_Q16 = 64'd20 << FB;
	localparam logic [21:0] LOG_SAT = 22'h3FFFFF;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [FB+4:0] variate;
		logic          clamped;
	} variate_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [evsw_pkg::IN_W-1:0]   uniform_word;
	logic                        out_valid;
	logic                        out_ready;
	logic [FB+4:0]               variate;
	logic                        clamped;
	logic                        cfg_we;
	logic [evsw_pkg::RATE_W-1:0] inverse_rate;

	// predictor state
	logic [21:0] log_hist[WIN];
	logic [25:0] log_sum;
	int          hist_count;
	int          hist_pos;
	logic [17:0] rate_q16;

	variate_t variate_q[$];
	int       fails;
	int       words_sent;
	int       variates_seen;
	int       clamps_seen;
	int       send_idle_pct;
	int       recv_stall_pct;
	int       hold_trig;
	int       hold_seen;
	int       hold_cnt;

	erlang_variate_sliding_window_core #(
		.WINDOW(WIN),
		.FRAC_BITS(FB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.uniform_word(uniform_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.variate(variate),
		.clamped(clamped),
		.cfg_we(cfg_we),
		.inverse_rate(inverse_rate)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[erlang_variate_sliding_window_core] ERROR");
		$finish;
	end

	// -ln(w / 2^64) in Q6.16, log2 by repeated squaring
	function automatic logic [21:0] neg_log_q16(input logic [63:0] w);
		logic [63:0] x;
		logic [63:0] m;
		logic [63:0] l2;
		logic [63:0] r;
		logic [19:0] frac;
		int          n;
		if (w == 64'd0)
			return LOG_SAT;
		x = w;
		n = 0;
		while (!x[63]) begin
			x = x << 1;
			n++;
		end
		m = x >> 32;
		frac = '0;
		for (int k = 0; k < FB + 4; k++) begin
			m = (m * m) >> 31;
			frac = {frac[18:0], 1'b0};
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		l2 = (64'(n + 1) << (FB + 4)) - 64'(frac);
		r = (l2 * 64'(evsw_pkg::LN2_Q28) + 64'h8000_0000) >> 32;
		if (r > 64'(LOG_SAT))
			r = 64'(LOG_SAT);
		return r[21:0];
	endfunction

	task automatic push_word(input logic [63:0] w);
		logic [21:0] lv;
		logic [63:0] prod;
		variate_t    res;
		lv = neg_log_q16(w);
		if (hist_count >= WIN)
			log_sum = log_sum - log_hist[hist_pos];
		log_sum = log_sum + lv;
		log_hist[hist_pos] = lv;
		hist_pos = (hist_pos + 1 >= WIN) ? 0 : hist_pos + 1;
		if (hist_count < WIN)
			hist_count++;
		if (hist_count >= WIN) begin
			prod = (64'(log_sum) * 64'(rate_q16) + 64'd32768) >> evsw_pkg::RATE_BITS;
			res.clamped = prod > LIMIT_Q16;
			if (res.clamped)
				prod = LIMIT_Q16;
			res.variate = prod[FB+4:0];
			variate_q.push_back(res);
		end
	endtask

	task automatic send_word(input logic [63:0] w);
		in_valid <= 1'b1;
		uniform_word <= w;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		push_word(w);
		words_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			uniform_word <= {$urandom, $urandom};
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (variate_q.size() != 0)
			@(posedge clk);
		// words before the window fills give no beat, so let them finish
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [17:0] r);
		wait_idle();
		cfg_we <= 1'b1;
		inverse_rate <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		inverse_rate <= 18'($urandom);
		rate_q16 = r;
	endtask

	function automatic logic [63:0] random_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(9))
			0: w = w >> $urandom_range(63, 1);
			1: w = w >> $urandom_range(63, 50);
			2: w = 64'd0;
			3: w = ~(w >> $urandom_range(63, 1));
			default: ;
		endcase
		return w;
	endfunction

	task automatic test_directed();
		logic [63:0] words[20];
		words = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 64'h0000_0001_0000_0000,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_FFFF_FFFF,
			64'hC000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'hF000_0000_0000_0001,
			64'h0000_0000_0000_0002, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0123_4567_89AB_CDEF,
			64'hFEDC_BA98_7654_3210, 64'h8000_0000_0000_0001, 64'h0000_8000_0000_0000,
			64'hB504_F333_F9DE_6484};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (words[i])
			send_word(words[i]);
		write_rate(18'd262143);
		for (int i = 0; i < 4; i++)
			send_word(words[i * 3]);
		write_rate(18'd1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic test_random(input int idle, input int stall, input logic [17:0] r);
		write_rate(r);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (370)
			send_word(random_word());
	endtask

	task automatic test_backpressure();
		wait_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_trig++;
		repeat (40)
			send_word(random_word());
	endtask

	// receiver side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_trig) begin
			hold_seen <= hold_trig;
			hold_cnt <= 400;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		variate_t want;
		if (arst_n && out_valid && out_ready) begin
			if (variate_q.size() == 0) begin
				$error("variate beat with nothing expected");
				fails++;
			end else begin
				want = variate_q.pop_front();
				variates_seen++;
				if (clamped)
					clamps_seen++;
				if (variate !== want.variate) begin
					$error("variate: expected %0d, got %0d", want.variate, variate);
					fails++;
				end
				if (clamped !== want.clamped) begin
					$error("clamped: expected %0d, got %0d", want.clamped, clamped);
					fails++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		uniform_word = '0;
		cfg_we = 1'b0;
		inverse_rate = '0;
		fails = 0;
		words_sent = 0;
		variates_seen = 0;
		clamps_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_trig = 0;
		log_sum = '0;
		hist_count = 0;
		hist_pos = 0;
		rate_q16 = evsw_pkg::RATE_RESET;
		foreach (log_hist[i])
			log_hist[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(0, 0, 18'($urandom_range(262143, 1)));
		test_random(81, 0, 18'd46811);
		test_random(0, 81, 18'($urandom_range(80000, 1)));
		test_random(13, 13, 18'($urandom_range(262143, 1)));
		test_backpressure();
		wait_idle();

		$display("covered %0d words and %0d variates (%0d clamped)",
			words_sent, variates_seen, clamps_seen);
		$display("rates from 1 to full scale, four idle/stall mixes, one long output hold");
		if (fails == 0)
			$display("[erlang_variate_sliding_window_core] OK");
		else
			$display("[erlang_variate_sliding_window_core] ERROR");
		$finish;
	end

endmodule
